@@ hw/rtl/nnsm_pkg.sv @@
// ----------------------------------------------------------------------------
// Nearest-neighbour scaler map package
// Shared widths, pipeline depths, register indexes and axis types.
// ----------------------------------------------------------------------------
`default_nettype none

package nnsm_pkg;

  localparam int COORD_BITS = 12;
  localparam int REG_BITS   = 13;
  localparam int CFG_IDX_W  = 3;

  localparam int PROD_W = 2 * REG_BITS;
  localparam int SAT_W  = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;
  localparam int OFF_W  = SAT_W + 2;

  localparam int DIV_STEPS     = REG_BITS;
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
  localparam int DIV_FIRST     = 2;
  localparam int AXIS_STAGES   = DIV_STAGES + DIV_FIRST;
  localparam int PIPE_STAGES   = AXIS_STAGES + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH   = 3'd0,
    CFG_SRC_HEIGHT  = 3'd1,
    CFG_WIN_LEFT    = 3'd2,
    CFG_WIN_TOP     = 3'd3,
    CFG_WIN_WIDTH   = 3'd4,
    CFG_WIN_HEIGHT  = 3'd5,
    CFG_DISP_WIDTH  = 3'd6,
    CFG_DISP_HEIGHT = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [REG_BITS-1:0] start;
    logic [REG_BITS-1:0] size;
    logic [REG_BITS-1:0] disp;
    logic [REG_BITS-1:0] src;
  } axis_cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/nnsm_axis.sv @@
// ----------------------------------------------------------------------------
// Nearest-neighbour scaler map, one axis
// Window hit test, offset times source size, pipelined restoring division
// by the window size and clamping of the source index.
// ----------------------------------------------------------------------------
`default_nettype none

module nnsm_axis (
  input  logic                                          clk_i,
  input  logic [nnsm_pkg::AXIS_STAGES-1:0]              en_i,
  input  logic [nnsm_pkg::COORD_BITS-1:0]               pos_i,
  input  nnsm_pkg::axis_cfg_t                           cfg_i,
  output logic                                          hit_o,
  output logic [nnsm_pkg::COORD_BITS-1:0]               idx_o
);

  localparam int RB = nnsm_pkg::REG_BITS;
  localparam int CB = nnsm_pkg::COORD_BITS;
  localparam int OW = nnsm_pkg::OFF_W;
  localparam int SW = nnsm_pkg::SAT_W;
  localparam int PW = nnsm_pkg::PROD_W;
  localparam int DS = nnsm_pkg::DIV_STAGES;
  localparam int DP = nnsm_pkg::DIV_PER_STAGE;
  localparam int DF = nnsm_pkg::DIV_FIRST;
  localparam logic [CB-1:0] COORD_MAX = '1;

  logic signed [OW-1:0] off;
  logic                 hit_d;
  logic                 hit0_q;
  logic [RB-1:0]        off0_q;
  logic                 hit1_q;
  logic [PW-1:0]        prod_q;

  logic          div_hit_q [DS];
  logic [RB-1:0] div_rem_q [DS];
  logic [RB-1:0] div_low_q [DS];
  logic [RB-1:0] div_rem_d [DS];
  logic [RB-1:0] div_low_d [DS];

  logic [RB-1:0] quo;
  logic [RB-1:0] clamped;
  logic [SW-1:0] clamped_ext;

  always_comb begin
    off   = $signed({{(OW-CB){1'b0}}, pos_i}) - $signed({{(OW-RB){cfg_i.start[RB-1]}},
                                                        cfg_i.start});
    hit_d = !off[OW-1]
            && (off[OW-2:0] < {{(OW-1-RB){1'b0}}, cfg_i.size})
            && (SW'(pos_i) < SW'(cfg_i.disp));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      hit0_q <= hit_d;
      off0_q <= off[RB-1:0];
    end
    if (en_i[1]) begin
      hit1_q <= hit0_q;
      prod_q <= off0_q * cfg_i.src;
    end
  end

  always_comb begin
    logic [RB-1:0] rem;
    logic [RB-1:0] low;
    logic [RB:0]   trial;
    logic          qbit;
    for (int s = 0; s < DS; s++) begin
      if (s == 0) begin
        rem = prod_q[PW-1:RB];
        low = prod_q[RB-1:0];
      end else begin
        rem = div_rem_q[s-1];
        low = div_low_q[s-1];
      end
      for (int k = 0; k < DP; k++) begin
        if (s * DP + k < nnsm_pkg::DIV_STEPS) begin
          trial = {rem, low[RB-1]};
          qbit  = (trial >= {1'b0, cfg_i.size});
          if (qbit) begin
            trial = trial - {1'b0, cfg_i.size};
          end
          rem = trial[RB-1:0];
          low = {low[RB-2:0], qbit};
        end
      end
      div_rem_d[s] = rem;
      div_low_d[s] = low;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DS; s++) begin
      if (en_i[s+DF]) begin
        div_hit_q[s] <= (s == 0) ? hit1_q : div_hit_q[(s == 0) ? 0 : s-1];
        div_rem_q[s] <= div_rem_d[s];
        div_low_q[s] <= div_low_d[s];
      end
    end
  end

  always_comb begin
    quo = div_low_q[DS-1];
    if (cfg_i.src == '0) begin
      clamped = '0;
    end else if (quo >= cfg_i.src) begin
      clamped = cfg_i.src - RB'(1);
    end else begin
      clamped = quo;
    end
    clamped_ext = SW'(clamped);
    if (clamped_ext > SW'(COORD_MAX)) begin
      idx_o = COORD_MAX;
    end else begin
      idx_o = clamped_ext[CB-1:0];
    end
    hit_o = div_hit_q[DS-1];
  end

endmodule

`default_nettype wire

@@ hw/rtl/nearest_neighbor_scaler_map.sv @@
// ----------------------------------------------------------------------------
// Nearest-neighbour scaler map
// Maps a display pixel to the source pixel of a scaled, clipped window.
// ----------------------------------------------------------------------------
// Usage: write the eight window and surface registers on the cfg channel
// while no beat is in flight; cfg_ready_o is always high. Then send one
// beat per display pixel (dest_col_i, dest_row_i) on the in channel. Each
// input beat gives exactly one output beat (hit_o, src_col_o, src_row_o),
// in order; src_col_o and src_row_o are zero when hit_o is low.
// Each beat passes through the hit stage, one multiplier stage, seven division
// stages resolving two quotient bits each except the last, which resolves
// one, and the output register. Throughput is one beat per cycle while the
// receiver does not stall.
// Reset loads the register reset values and empties the pipeline.
// When the receiver stalls, the output beat holds, earlier stages keep
// closing bubbles, and in_stall_o rises only once every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_scaler_map (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [nnsm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [nnsm_pkg::REG_BITS-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [nnsm_pkg::COORD_BITS-1:0]      dest_col_i,
  input  logic [nnsm_pkg::COORD_BITS-1:0]      dest_row_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 hit_o,
  output logic [nnsm_pkg::COORD_BITS-1:0]      src_col_o,
  output logic [nnsm_pkg::COORD_BITS-1:0]      src_row_o
);

  localparam int RB = nnsm_pkg::REG_BITS;
  localparam int CB = nnsm_pkg::COORD_BITS;
  localparam int NS = nnsm_pkg::PIPE_STAGES;
  localparam int AS = nnsm_pkg::AXIS_STAGES;

  logic [RB-1:0] src_width_q, src_height_q, win_left_q, win_top_q;
  logic [RB-1:0] win_width_q, win_height_q, disp_width_q, disp_height_q;

  logic [NS-1:0] valid_q, valid_d;
  logic [NS:0]   ready;

  nnsm_pkg::axis_cfg_t col_cfg, row_cfg;
  logic          col_hit, row_hit;
  logic [CB-1:0] col_idx, row_idx;

  logic          hit_q;
  logic [CB-1:0] src_col_q, src_row_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q   <= RB'(1);
      src_height_q  <= RB'(1);
      win_left_q    <= '0;
      win_top_q     <= '0;
      win_width_q   <= '0;
      win_height_q  <= '0;
      disp_width_q  <= RB'(1);
      disp_height_q <= RB'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (nnsm_pkg::cfg_reg_e'(cfg_index_i))
        nnsm_pkg::CFG_SRC_WIDTH:   src_width_q   <= cfg_data_i;
        nnsm_pkg::CFG_SRC_HEIGHT:  src_height_q  <= cfg_data_i;
        nnsm_pkg::CFG_WIN_LEFT:    win_left_q    <= cfg_data_i;
        nnsm_pkg::CFG_WIN_TOP:     win_top_q     <= cfg_data_i;
        nnsm_pkg::CFG_WIN_WIDTH:   win_width_q   <= cfg_data_i;
        nnsm_pkg::CFG_WIN_HEIGHT:  win_height_q  <= cfg_data_i;
        nnsm_pkg::CFG_DISP_WIDTH:  disp_width_q  <= cfg_data_i;
        nnsm_pkg::CFG_DISP_HEIGHT: disp_height_q <= cfg_data_i;
        default:                   ;
      endcase
    end
  end

  always_comb begin
    ready[NS] = !out_stall_i;
    for (int i = NS - 1; i >= 0; i--) begin
      ready[i] = !valid_q[i] || ready[i+1];
    end
    for (int i = 0; i < NS; i++) begin
      if (ready[i]) begin
        valid_d[i] = (i == 0) ? in_valid_i : valid_q[(i == 0) ? 0 : i-1];
      end else begin
        valid_d[i] = valid_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o = !ready[0];

  assign col_cfg = '{start: win_left_q, size: win_width_q, disp: disp_width_q,
                     src: src_width_q};
  assign row_cfg = '{start: win_top_q, size: win_height_q, disp: disp_height_q,
                     src: src_height_q};

  nnsm_axis u_col (
    .clk_i (clk_i),
    .en_i  (ready[AS-1:0]),
    .pos_i (dest_col_i),
    .cfg_i (col_cfg),
    .hit_o (col_hit),
    .idx_o (col_idx)
  );

  nnsm_axis u_row (
    .clk_i (clk_i),
    .en_i  (ready[AS-1:0]),
    .pos_i (dest_row_i),
    .cfg_i (row_cfg),
    .hit_o (row_hit),
    .idx_o (row_idx)
  );

  always_ff @(posedge clk_i) begin
    if (ready[NS-1]) begin
      hit_q     <= col_hit && row_hit;
      src_col_q <= (col_hit && row_hit) ? col_idx : '0;
      src_row_q <= (col_hit && row_hit) ? row_idx : '0;
    end
  end

  assign out_valid_o = valid_q[NS-1];
  assign hit_o       = hit_q;
  assign src_col_o   = src_col_q;
  assign src_row_o   = src_row_q;

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> (src_col_o == '0) && (src_row_o == '0))
    else $error("miss beat carries a non-zero source index");

  a_col_in_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o && (src_width_q != '0) |-> (src_col_o < src_width_q))
    else $error("source column beyond source width");

  a_row_in_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o && (src_height_q != '0) |-> (src_row_o < src_height_q))
    else $error("source row beyond source height");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled while the pipeline has a bubble");

endmodule

`default_nettype wire

@@ test/nearest_neighbor_scaler_map_checker.sv @@
// ----------------------------------------------------------------------------
// Nearest-neighbour scaler map checker
// Watches the register, input and output channels of the scaler map. It
// keeps its own copy of the window registers, predicts the source pixel of
// every accepted input beat, and compares each output beat field by field
// with the oldest prediction still awaited.
// ----------------------------------------------------------------------------

module nearest_neighbor_scaler_map_checker
  import nnsm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [REG_BITS-1:0]   cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [COORD_BITS-1:0] dest_col_i,
  input  logic [COORD_BITS-1:0] dest_row_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  hit_i,
  input  logic [COORD_BITS-1:0] src_col_i,
  input  logic [COORD_BITS-1:0] src_row_i,
  output int                    mismatches_o,
  output int                    due_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  hit;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } source_pixel_t;

  logic [REG_BITS-1:0] window_regs [8];
  source_pixel_t       awaited_pixels [$];

  initial mismatches_o = 0;

  function automatic logic locate_on_axis(input logic [COORD_BITS-1:0] pos,
                                          input logic [REG_BITS-1:0] start_bits,
                                          input logic [REG_BITS-1:0] size,
                                          input logic [REG_BITS-1:0] disp,
                                          input logic [REG_BITS-1:0] src,
                                          output logic [COORD_BITS-1:0] idx);
    longint start;
    longint lo;
    longint hi;
    longint off;
    longint q;
    start = longint'($signed(start_bits));
    lo = (start > 0) ? start : 0;
    hi = start + longint'(size);
    if (hi > longint'(disp)) begin
      hi = longint'(disp);
    end
    idx = '0;
    if (size == '0 || longint'(pos) < lo || longint'(pos) >= hi) begin
      return 1'b0;
    end
    off = longint'(pos) - start;
    q = (off * longint'(src)) / longint'(size);
    if (src == '0) begin
      q = 0;
    end else if (q >= longint'(src)) begin
      q = longint'(src) - 1;
    end
    if (q > (longint'(1) << COORD_BITS) - 1) begin
      q = (longint'(1) << COORD_BITS) - 1;
    end
    idx = q[COORD_BITS-1:0];
    return 1'b1;
  endfunction

  function automatic source_pixel_t nearest_source(input logic [COORD_BITS-1:0] col,
                                                   input logic [COORD_BITS-1:0] row);
    source_pixel_t         px;
    logic                  col_in;
    logic                  row_in;
    logic [COORD_BITS-1:0] sc;
    logic [COORD_BITS-1:0] sr;
    col_in = locate_on_axis(col, window_regs[CFG_WIN_LEFT], window_regs[CFG_WIN_WIDTH],
                            window_regs[CFG_DISP_WIDTH], window_regs[CFG_SRC_WIDTH], sc);
    row_in = locate_on_axis(row, window_regs[CFG_WIN_TOP], window_regs[CFG_WIN_HEIGHT],
                            window_regs[CFG_DISP_HEIGHT], window_regs[CFG_SRC_HEIGHT], sr);
    px = '0;
    if (col_in && row_in) begin
      px.hit = 1'b1;
      px.col = sc;
      px.row = sr;
    end
    return px;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatches_o++;
    if (mismatches_o <= 50) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    source_pixel_t want;
    if (!rst_ni) begin
      window_regs[CFG_SRC_WIDTH]   = 13'd1;
      window_regs[CFG_SRC_HEIGHT]  = 13'd1;
      window_regs[CFG_WIN_LEFT]    = 13'd0;
      window_regs[CFG_WIN_TOP]     = 13'd0;
      window_regs[CFG_WIN_WIDTH]   = 13'd0;
      window_regs[CFG_WIN_HEIGHT]  = 13'd0;
      window_regs[CFG_DISP_WIDTH]  = 13'd1;
      window_regs[CFG_DISP_HEIGHT] = 13'd1;
      awaited_pixels.delete();
      due_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        window_regs[cfg_index_i] = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_pixels.size() == 0) begin
          report_mismatch("unawaited result beat", 0, 1);
        end else begin
          want = awaited_pixels.pop_front();
          if (hit_i !== want.hit) begin
            report_mismatch("hit", want.hit, hit_i);
          end
          if (src_col_i !== want.col) begin
            report_mismatch("src_col", want.col, src_col_i);
          end
          if (src_row_i !== want.row) begin
            report_mismatch("src_row", want.row, src_row_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_pixels.push_back(nearest_source(dest_col_i, dest_row_i));
      end
      due_o = awaited_pixels.size();
    end
  end

endmodule

@@ test/tb_nearest_neighbor_scaler_map.sv @@
// ----------------------------------------------------------------------------
// Nearest-neighbour scaler map testbench
// Programs a series of window, source and display settings, from the reset
// values through saturating, empty and off-screen extremes to random ones,
// and sends display pixels near and across each window edge. Both sides
// idle at random, and the receiver once holds off long enough to fill the
// pipeline. A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------

module tb_nearest_neighbor_scaler_map;

  timeunit 1ns;
  timeprecision 1ps;

  import nnsm_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_e              cfg_index = CFG_SRC_WIDTH;
  logic [REG_BITS-1:0]   cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [COORD_BITS-1:0] dest_col  = '0;
  logic [COORD_BITS-1:0] dest_row  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  hit;
  logic [COORD_BITS-1:0] src_col;
  logic [COORD_BITS-1:0] src_row;

  int                    mismatches;
  int                    due;
  bit                    calm        = 1'b0;
  bit                    squeeze_req = 1'b0;
  logic [REG_BITS-1:0]   win_regs [8];

  nearest_neighbor_scaler_map i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .dest_col_i  (dest_col),
    .dest_row_i  (dest_row),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .hit_o       (hit),
    .src_col_o   (src_col),
    .src_row_o   (src_row)
  );

  nearest_neighbor_scaler_map_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .dest_col_i   (dest_col),
    .dest_row_i   (dest_row),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .hit_i        (hit),
    .src_col_i    (src_col),
    .src_row_i    (src_row),
    .mismatches_o (mismatches),
    .due_o        (due)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_stall = 1'b1;
        repeat (80) @(negedge clk);
      end
      out_stall = !calm && ($urandom_range(0, 99) < 21);
    end
  end

  task automatic send_pixel(input logic [COORD_BITS-1:0] col,
                            input logic [COORD_BITS-1:0] row);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    dest_col = col;
    dest_row = row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reconfigure(input logic [REG_BITS-1:0] sw, input logic [REG_BITS-1:0] sh,
                             input logic [REG_BITS-1:0] left, input logic [REG_BITS-1:0] top,
                             input logic [REG_BITS-1:0] ww, input logic [REG_BITS-1:0] wh,
                             input logic [REG_BITS-1:0] dw, input logic [REG_BITS-1:0] dh);
    in_valid = 1'b0;
    while (due != 0) @(negedge clk);
    win_regs[CFG_SRC_WIDTH]   = sw;
    win_regs[CFG_SRC_HEIGHT]  = sh;
    win_regs[CFG_WIN_LEFT]    = left;
    win_regs[CFG_WIN_TOP]     = top;
    win_regs[CFG_WIN_WIDTH]   = ww;
    win_regs[CFG_WIN_HEIGHT]  = wh;
    win_regs[CFG_DISP_WIDTH]  = dw;
    win_regs[CFG_DISP_HEIGHT] = dh;
    for (int i = 0; i < 8; i++) begin
      cfg_valid = 1'b1;
      cfg_index = cfg_reg_e'(i);
      cfg_data  = win_regs[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  function automatic logic [REG_BITS-1:0] rand_extent();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return REG_BITS'($urandom);
      2:       return 13'd4096;
      3:       return 13'd1;
      default: return REG_BITS'($urandom_range(1, 200));
    endcase
  endfunction

  function automatic logic [REG_BITS-1:0] rand_start();
    if ($urandom_range(0, 99) < 20) begin
      return REG_BITS'($urandom);
    end
    return REG_BITS'($urandom_range(0, 400)) - 13'd60;
  endfunction

  function automatic logic [REG_BITS-1:0] rand_display();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return REG_BITS'($urandom);
      2:       return 13'd4096;
      default: return REG_BITS'($urandom_range(1, 500));
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord(input logic [REG_BITS-1:0] start,
                                                       input logic [REG_BITS-1:0] size);
    longint p;
    if ($urandom_range(0, 99) < 15) begin
      return COORD_BITS'($urandom);
    end
    p = longint'($signed(start)) + longint'($urandom_range(0, int'(size) + 7)) - 4;
    if (p < 0) begin
      return COORD_BITS'($urandom_range(0, 3));
    end
    if (p > 4095) begin
      return COORD_BITS'(4095 - $urandom_range(0, 3));
    end
    return p[COORD_BITS-1:0];
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);

    reconfigure(13'd64, 13'd48, 13'd10, 13'd5, 13'd64, 13'd48, 13'd640, 13'd480);
    send_pixel(12'd10, 12'd5);
    send_pixel(12'd73, 12'd52);
    send_pixel(12'd9, 12'd5);
    send_pixel(12'd74, 12'd52);

    reconfigure(13'd8191, 13'd8191, 13'd0, 13'd0, 13'd4096, 13'd4096, 13'd8191, 13'd8191);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd1);

    reconfigure(13'd0, 13'd0, 13'h1000, 13'h1000, 13'd8191, 13'd8191, 13'd4096, 13'd4096);
    send_pixel(12'd4094, 12'd4094);
    send_pixel(12'd4095, 12'd0);

    reconfigure(13'd100, 13'd100, 13'd0, 13'd0, 13'd100, 13'd100, 13'd0, 13'd0);
    send_pixel(12'd0, 12'd0);

    reconfigure(13'd100, 13'd100, 13'd0, 13'd0, 13'd100, 13'd0, 13'd4096, 13'd4096);
    send_pixel(12'd5, 12'd5);

    reconfigure(13'd4096, 13'd1, 13'd4095, 13'd0, 13'd1, 13'd4096, 13'd4096, 13'd4096);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4094, 12'd0);

    for (int w = 0; w < 16; w++) begin
      reconfigure(rand_extent(), rand_extent(), rand_start(), rand_start(),
                  rand_extent(), rand_extent(), rand_display(), rand_display());
      calm = (w == 6 || w == 7);
      for (int n = 0; n < 100; n++) begin
        if (w == 3 && n == 20) begin
          squeeze_req = 1'b1;
        end
        send_pixel(pick_coord(win_regs[CFG_WIN_LEFT], win_regs[CFG_WIN_WIDTH]),
                   pick_coord(win_regs[CFG_WIN_TOP], win_regs[CFG_WIN_HEIGHT]));
      end
    end
    calm = 1'b0;

    in_valid = 1'b0;
    while (due != 0) @(negedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
